// ===== hdl/llq_pkg.sv =====
// shared types and constants for the linked-list queue with free list
`default_nettype none
package llq_pkg;

    localparam int NODE_COUNT_DEF = 16;
    localparam int DATA_W         = 8;

    typedef enum logic [1:0] {
        OP_ENQ = 2'd0,
        OP_DEQ = 2'd1,
        OP_INS = 2'd2,
        OP_CLR = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_FRONT,
        S_RESP
    } t_state;

endpackage
`default_nettype wire

// ===== hdl/linked_list_queue_free_list.sv =====
// byte queue as a linked list in a node store, free nodes on a second list
// each accepted request runs through the execute state, then strobes o_valid in the
//   result state; a dequeue that leaves bytes queued passes a front state between them
//   (extra data read); a new item can start in the strobe cycle, the link memory being
//   read at accept and written back in the execute state for each item
// reset: synchronous, active low; afterwards a sweep chains all nodes onto the free list,
//   busy stays high until the state machine has left its init state after the sweep;
//   receiver cannot stall
`default_nettype none
module linked_list_queue_free_list #(
    parameter int NODE_COUNT = llq_pkg::NODE_COUNT_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [1:0]                 i_op,
    input  wire logic [llq_pkg::DATA_W-1:0] i_elem,
    output logic                            o_valid,
    output logic [1:0]                      o_status,
    output logic [llq_pkg::DATA_W-1:0]      o_front_byte,
    output logic                            o_is_empty,
    output logic                            o_is_full
);
    import llq_pkg::*;

    localparam int AW = $clog2(NODE_COUNT);
    localparam int LW = $clog2(NODE_COUNT + 1);
    localparam logic [LW-1:0] NULL_LINK = LW'(NODE_COUNT);
    localparam logic [LW-1:0] LAST_NODE = LW'(NODE_COUNT - 1);

    // links at or above the node count are all treated as null
    function automatic logic is_node(input logic [LW-1:0] idx);
        return idx < NULL_LINK;
    endfunction

    t_state            r_state;
    t_state            n_state;
    t_op               r_op;
    logic [DATA_W-1:0] r_elem;
    logic [LW-1:0]     r_head;
    logic [LW-1:0]     n_head;
    logic [LW-1:0]     r_tail;
    logic [LW-1:0]     n_tail;
    logic [LW-1:0]     r_free_head;
    logic [LW-1:0]     n_free_head;
    logic [DATA_W-1:0] r_front;
    logic [DATA_W-1:0] n_front;
    t_status           r_status;
    t_status           n_status;

    logic              accept;
    logic              init_busy;
    logic              need_front;

    // link memory port
    logic              link_rd_en;
    logic [AW-1:0]     link_rd_addr;
    logic [LW-1:0]     link_rd_data;
    logic              link_wr_en;
    logic [AW-1:0]     link_wr_addr;
    logic [LW-1:0]     link_wr_data;
    logic [LW-1:0]     next_link;

    // data memory port
    logic              data_rd_en;
    logic [AW-1:0]     data_rd_addr;
    logic [DATA_W-1:0] data_rd_data;
    logic              data_wr_en;
    logic [AW-1:0]     data_wr_addr;

    llq_link_mem #(
        .NODE_COUNT (NODE_COUNT)
    ) u_link_mem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (link_rd_en),
        .i_rd_addr   (link_rd_addr),
        .o_rd_data   (link_rd_data),
        .i_wr_en     (link_wr_en),
        .i_wr_addr   (link_wr_addr),
        .i_wr_data   (link_wr_data),
        .o_init_busy (init_busy)
    );

    llq_data_mem #(
        .NODE_COUNT (NODE_COUNT)
    ) u_data_mem (
        .i_clk     (i_clk),
        .i_rd_en   (data_rd_en),
        .i_rd_addr (data_rd_addr),
        .o_rd_data (data_rd_data),
        .i_wr_en   (data_wr_en),
        .i_wr_addr (data_wr_addr),
        .i_wr_data (r_elem)
    );

    assign accept = start && !busy;

    // at accept, fetch the link of the node the op works on:
    // queue front for dequeue, first free node otherwise
    always_comb begin
        if (t_op'(i_op) == OP_DEQ) begin
            link_rd_addr = r_head[AW-1:0];
            link_rd_en   = accept && is_node(r_head);
        end else begin
            link_rd_addr = r_free_head[AW-1:0];
            link_rd_en   = accept && is_node(r_free_head);
        end
    end

    assign next_link = is_node(link_rd_data) ? link_rd_data : NULL_LINK;

    // execute step: link read has landed, modify pointers and write back.
    // the tail's own link is never relied on: a one-node queue is found by head == tail
    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_free_head  = r_free_head;
        n_front      = r_front;
        n_status     = r_status;
        link_wr_en   = 1'b0;
        link_wr_addr = r_free_head[AW-1:0];
        link_wr_data = r_head;
        data_wr_en   = 1'b0;
        data_wr_addr = r_free_head[AW-1:0];
        data_rd_en   = 1'b0;
        data_rd_addr = next_link[AW-1:0];
        need_front   = 1'b0;
        if (r_state == S_EXEC) begin
            n_status = ST_DONE;
            case (r_op)
                OP_ENQ: begin
                    if (!is_node(r_free_head)) begin
                        n_status = ST_FULL;
                    end else begin
                        n_free_head = next_link;
                        data_wr_en  = 1'b1;
                        if (!is_node(r_head)) begin
                            n_head  = r_free_head;
                            n_front = r_elem;
                        end else if (is_node(r_tail)) begin
                            link_wr_en   = 1'b1;
                            link_wr_addr = r_tail[AW-1:0];
                            link_wr_data = r_free_head;
                        end
                        n_tail = r_free_head;
                    end
                end
                OP_DEQ: begin
                    if (!is_node(r_head)) begin
                        n_status = ST_EMPTY;
                    end else begin
                        link_wr_en   = 1'b1;
                        link_wr_addr = r_head[AW-1:0];
                        link_wr_data = r_free_head;
                        n_free_head  = r_head;
                        if (r_head == r_tail || !is_node(next_link)) begin
                            n_head = NULL_LINK;
                            n_tail = NULL_LINK;
                        end else begin
                            n_head     = next_link;
                            data_rd_en = 1'b1;
                            need_front = 1'b1;
                        end
                    end
                end
                OP_INS: begin
                    if (!is_node(r_free_head)) begin
                        n_status = ST_FULL;
                    end else begin
                        n_free_head  = next_link;
                        data_wr_en   = 1'b1;
                        link_wr_en   = 1'b1;
                        link_wr_data = r_head;
                        n_head       = r_free_head;
                        n_front      = r_elem;
                        if (!is_node(r_tail)) begin
                            n_tail = r_free_head;
                        end
                    end
                end
                default: begin
                    // clear: splice the whole queue in front of the free list
                    if (is_node(r_head) && is_node(r_tail)) begin
                        link_wr_en   = 1'b1;
                        link_wr_addr = r_tail[AW-1:0];
                        link_wr_data = r_free_head;
                        n_free_head  = r_head;
                    end
                    n_head = NULL_LINK;
                    n_tail = NULL_LINK;
                end
            endcase
        end else if (r_state == S_FRONT) begin
            n_front = data_rd_data;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT:  n_state = init_busy ? S_INIT : S_IDLE;
            S_IDLE:  n_state = start ? S_EXEC : S_IDLE;
            S_EXEC:  n_state = need_front ? S_FRONT : S_RESP;
            S_FRONT: n_state = S_RESP;
            S_RESP:  n_state = start ? S_EXEC : S_IDLE;
            default: n_state = S_INIT;
        endcase
    end

    // control outputs: a new item may enter while the result is shown
    always_comb begin
        busy    = 1'b1;
        o_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                busy = 1'b0;
            end
            S_RESP: begin
                busy    = 1'b0;
                o_valid = 1'b1;
            end
            default: begin
                busy    = 1'b1;
                o_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_head      <= NULL_LINK;
            r_tail      <= NULL_LINK;
            r_free_head <= LAST_NODE;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_free_head <= n_free_head;
        end
    end

    // item payload and result fields
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= t_op'(i_op);
            r_elem <= i_elem;
        end
        r_front  <= n_front;
        r_status <= n_status;
    end

    // result fields follow the pointer registers after the operation
    assign o_status     = r_status;
    assign o_is_empty   = !is_node(r_head);
    assign o_is_full    = !is_node(r_free_head);
    assign o_front_byte = is_node(r_head) ? r_front : '0;

    // head and tail are null together
    a_head_tail_null: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_node(r_head) == is_node(r_tail))
        else $error("head and tail disagree on empty queue");

    // a queued node never sits at the free list head
    a_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        is_node(r_head) |-> (r_head != r_free_head))
        else $error("front node also on free list");

    // result strobe lasts a single cycle
    a_strobe_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held");

    // a refused enqueue or insert leaves the store full
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_status == ST_FULL) |-> o_is_full)
        else $error("full status with free node");

    // a refused dequeue leaves the queue empty
    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_status == ST_EMPTY) |-> o_is_empty)
        else $error("empty status with queued byte");

endmodule
`default_nettype wire

// ===== hdl/llq_data_mem.sv =====
// node byte store: one write port, one registered read port
`default_nettype none
module llq_data_mem #(
    parameter int NODE_COUNT = llq_pkg::NODE_COUNT_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rd_en,
    input  wire logic [$clog2(NODE_COUNT)-1:0]      i_rd_addr,
    output logic      [llq_pkg::DATA_W-1:0]         o_rd_data,
    input  wire logic                               i_wr_en,
    input  wire logic [$clog2(NODE_COUNT)-1:0]      i_wr_addr,
    input  wire logic [llq_pkg::DATA_W-1:0]         i_wr_data
);
    import llq_pkg::*;

    logic [DATA_W-1:0] r_mem [NODE_COUNT];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== hdl/llq_link_mem.sv =====
// node link store with the power-up sweep that chains every node onto the free list
`default_nettype none
module llq_link_mem #(
    parameter int NODE_COUNT = llq_pkg::NODE_COUNT_DEF,
    localparam int AW = $clog2(NODE_COUNT),
    localparam int LW = $clog2(NODE_COUNT + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [LW-1:0] o_rd_data,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [LW-1:0] i_wr_data,
    output logic               o_init_busy
);

    localparam logic [LW-1:0] NULL_LINK = LW'(NODE_COUNT);
    localparam logic [AW-1:0] LAST_ADDR = AW'(NODE_COUNT - 1);

    logic [LW-1:0] r_mem [NODE_COUNT];
    logic          r_init_busy;
    logic          n_init_busy;
    logic [AW-1:0] r_init_cnt;
    logic [AW-1:0] n_init_cnt;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [LW-1:0] wr_data;

    // sweep: node i links to i-1, node 0 holds null
    always_comb begin
        n_init_busy = r_init_busy;
        n_init_cnt  = r_init_cnt;
        if (r_init_busy) begin
            if (r_init_cnt == LAST_ADDR) begin
                n_init_busy = 1'b0;
            end else begin
                n_init_cnt = r_init_cnt + AW'(1);
            end
        end
    end

    always_comb begin
        if (r_init_busy) begin
            wr_en   = 1'b1;
            wr_addr = r_init_cnt;
            wr_data = (r_init_cnt == '0) ? NULL_LINK : LW'(r_init_cnt - AW'(1));
        end else begin
            wr_en   = i_wr_en;
            wr_addr = i_wr_addr;
            wr_data = i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_busy <= 1'b1;
            r_init_cnt  <= '0;
        end else begin
            r_init_busy <= n_init_busy;
            r_init_cnt  <= n_init_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_init_busy = r_init_busy;

endmodule
`default_nettype wire
